/* design/priority_then_key_sorter_unit_assert.svh */
// Assertion macros for the priority-then-key sorter.
// Included by the modules that check their own logic; needs no package.
`ifndef PRIORITY_THEN_KEY_SORTER_UNIT_ASSERT_SVH
`define PRIORITY_THEN_KEY_SORTER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define PTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define PTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define PTS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PTS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/pts_pkg.sv */
// Shared types and constants for the priority-then-key sorter.
// No dependencies; imported by every module of the block.
package pts_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int REF_W           = 16;
   localparam int KEY_W           = 16;

   typedef struct packed {
      logic [REF_W-1:0] entry_ref;
      logic [KEY_W-1:0] entry_key;
      logic             priority_flag;
      logic             last_in;
   } req_type;

   typedef struct packed {
      logic [REF_W-1:0] out_ref;
      logic [KEY_W-1:0] out_key;
      logic             out_priority;
      logic             last_out;
      logic             overflow;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic [REF_W-1:0] ref_val;
      logic [KEY_W-1:0] key;
      logic             flag;
   } rec_type;

   // Sequencer commands to the compare unit.
   typedef struct packed {
      logic new_run;     // forget previous pick and best
      logic clear_best;  // start another scan of the same run
      logic commit;      // current best has been delivered
   } ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

/* design/pts_store.sv */
// Record memory: one write port, one read port with registered data.
// Depends on pts_pkg.
module pts_store
   import pts_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
   input  rec_type                        wr_rec,
   input  logic                           rd_en,
   input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
   output logic                           rd_valid,
   output logic [$clog2(MAX_ENTRIES)-1:0] rd_idx,
   output rec_type                        rd_rec
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);

   rec_type             mem_ff [MAX_ENTRIES];
   rec_type             rd_rec_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= mem_ff[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_idx   = rd_idx_ff;
   assign rd_rec   = rd_rec_ff;

endmodule

/* design/pts_min_unit.sv */
// Shared compare unit: finds the smallest sort key above the last one delivered.
// Sort key is {not flag, key, arrival index}, so ties fall back to arrival order.
// Depends on pts_pkg.
module pts_min_unit
   import pts_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctrl_type                       ctrl,
   input  logic                           rd_valid,
   input  logic [$clog2(MAX_ENTRIES)-1:0] rd_idx,
   input  rec_type                        rd_rec,
   output logic                           best_valid,
   output rec_type                        best_rec
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int SK_W  = 1 + KEY_W + IDX_W;

   logic [SK_W-1:0] cand_sk;
   logic [SK_W-1:0] best_sk_ff;
   logic [SK_W-1:0] prev_sk_ff;
   rec_type         best_rec_ff;
   logic            best_valid_ff;
   logic            prev_valid_ff;
   logic            take;

   assign cand_sk = {~rd_rec.flag, rd_rec.key, rd_idx};
   assign take    = rd_valid
                    && (!prev_valid_ff || (cand_sk > prev_sk_ff))
                    && (!best_valid_ff || (cand_sk < best_sk_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else if (ctrl.new_run) begin
         best_valid_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
      end else begin
         if (ctrl.commit) begin
            prev_valid_ff <= 1'b1;
         end
         if (ctrl.clear_best) begin
            best_valid_ff <= 1'b0;
         end else if (take) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         prev_sk_ff <= best_sk_ff;
      end
      if (take) begin
         best_sk_ff  <= cand_sk;
         best_rec_ff <= rd_rec;
      end
   end

   assign best_valid = best_valid_ff;
   assign best_rec   = best_rec_ff;

endmodule

/* design/priority_then_key_sorter_unit.sv */
// Priority-then-key sorter, top level.
// Depends on pts_pkg, pts_store, pts_min_unit and the assertion macro header.
//
// Use: send records on the req_ channel, one word per record. While loading,
// req_ready is high and a word is taken every cycle. Up to MAX_ENTRIES records
// are kept; later ones are dropped and the run is marked with overflow.
// The word with last_in set closes the set; req_ready then falls until the
// whole sorted run has left on the rsp_ channel.
// Order of the run: flagged records first, then the rest, each group by
// ascending key, equal keys in arrival order. last_out marks the final word.
// Each result word costs one scan of the stored records through the single
// compare unit, after which the word is shown on rsp_valid until it is taken.
// A stalled receiver simply holds the current word on rsp_data; the scan for
// the next word starts once it is taken.
// Reset (synchronous, active high) empties the store and returns to loading;
// memory contents are not cleared, since only written entries are ever read.
`include "priority_then_key_sorter_unit_assert.svh"

module priority_then_key_sorter_unit
   import pts_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             dropped_ff, dropped_in;
   logic             ovf_ff, ovf_in;

   logic             req_fire, rsp_fire;
   logic             has_room, wr_en, rd_en, is_last;
   rec_type          wr_rec;
   ctrl_type         ctrl;

   logic             rd_valid;
   logic [IDX_W-1:0] rd_idx;
   rec_type          rd_rec;
   logic             best_valid;
   rec_type          best_rec;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign has_room  = (count_ff < CNT_W'(MAX_ENTRIES));
   assign wr_en     = req_fire && has_room;
   assign wr_rec    = '{ref_val: req_data.entry_ref, key: req_data.entry_key,
                        flag: req_data.priority_flag};
   assign rd_en     = (state_ff == ST_SCAN) && (issue_ff < n_ff);
   assign is_last   = (CNT_W'(pos_ff) == (n_ff - CNT_W'(1)));

   assign ctrl.new_run    = req_fire && req_data.last_in;
   assign ctrl.clear_best = rsp_fire && !is_last;
   assign ctrl.commit     = rsp_fire;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      n_in       = n_ff;
      issue_in   = issue_ff;
      pos_in     = pos_ff;
      dropped_in = dropped_ff;
      ovf_in     = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_in) begin
                  n_in     = has_room ? count_ff + CNT_W'(1) : count_ff;
                  ovf_in   = dropped_ff || !has_room;
                  issue_in = '0;
                  pos_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end else if (!rd_valid) begin
               // last read word has been compared
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (is_last) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  pos_in   = pos_ff + IDX_W'(1);
                  issue_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         issue_ff   <= '0;
         pos_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         issue_ff   <= issue_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      ovf_ff <= ovf_in;
   end

   pts_store #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IDX_W-1:0]),
      .wr_rec   (wr_rec),
      .rd_en    (rd_en),
      .rd_addr  (issue_ff[IDX_W-1:0]),
      .rd_valid (rd_valid),
      .rd_idx   (rd_idx),
      .rd_rec   (rd_rec)
   );

   pts_min_unit #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_min (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .rd_valid   (rd_valid),
      .rd_idx     (rd_idx),
      .rd_rec     (rd_rec),
      .best_valid (best_valid),
      .best_rec   (best_rec)
   );

   assign rsp_data = '{out_ref: best_rec.ref_val, out_key: best_rec.key,
                       out_priority: best_rec.flag, last_out: is_last,
                       overflow: ovf_ff};

   `PTS_ASSERT_NOW(a_emit_has_pick, clock, reset, state_ff == ST_EMIT, best_valid)
   `PTS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES))
   `PTS_ASSERT_NOW(a_no_load_in_run, clock, reset, rsp_valid, !req_ready)
   `PTS_ASSERT_NEXT(a_run_end_loads, clock, reset, rsp_fire && is_last, req_ready && count_ff == '0)
   `PTS_ASSERT_NEXT(a_rescan, clock, reset, rsp_fire && !is_last, state_ff == ST_SCAN && !best_valid)

endmodule
